/* src/rsitp_pkg.sv */
// Shared constants, codes and control structs of the return stack / indirect target predictor.
package rsitp_pkg;

    localparam int ADDR_W = 64;
    localparam int SIZE_W = 4;
    localparam int HIST_W = 12;
    localparam int KIND_W = 3;

    localparam int DEF_STACK_DEPTH      = 32;
    localparam int DEF_INDIRECT_ENTRIES = 4096;
    localparam int DEF_CALL_SIZE_ENTRIES = 1024;

    localparam logic [SIZE_W-1:0] LIMIT_RESET     = 4'd10;
    localparam logic [SIZE_W-1:0] CALL_SIZE_RESET = 4'd4;

    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_COND     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_JUMP     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INDIRECT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CALL     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_IND_CALL = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RETURN   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_OTHER    = 3'd6;

    typedef struct packed {
        logic push;
        logic pop;
    } stk_req_t;

    typedef struct packed {
        logic busy;
        logic ind_we;
        logic cs_we;
    } clr_ctl_t;

endpackage

/* src/rsitp_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module rsitp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/rsitp_clear.sv */
// Post-reset sweep that initializes the indirect target and call-size tables.
module rsitp_clear import rsitp_pkg::*; #(
    parameter int INDIRECT_ENTRIES  = DEF_INDIRECT_ENTRIES,
    parameter int CALL_SIZE_ENTRIES = DEF_CALL_SIZE_ENTRIES,
    localparam int CLR_DEPTH = (INDIRECT_ENTRIES > CALL_SIZE_ENTRIES) ?
                               INDIRECT_ENTRIES : CALL_SIZE_ENTRIES,
    localparam int CLR_AW    = $clog2(CLR_DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    output clr_ctl_t          ctl,
    output logic [CLR_AW-1:0] addr
);

    logic              busy_reg;
    logic              busy_next;
    logic [CLR_AW-1:0] cnt_reg;
    logic [CLR_AW-1:0] cnt_next;
    logic              last;

    assign last = (cnt_reg == CLR_AW'(CLR_DEPTH - 1));

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign ctl.busy   = busy_reg;
    assign ctl.ind_we = busy_reg &&
                        ((CLR_AW+1)'(cnt_reg) < (CLR_AW+1)'(INDIRECT_ENTRIES));
    assign ctl.cs_we  = busy_reg &&
                        ((CLR_AW+1)'(cnt_reg) < (CLR_AW+1)'(CALL_SIZE_ENTRIES));
    assign addr       = cnt_reg;

endmodule

/* src/rsitp_stack.sv */
// Circular return stack: pointer, per-entry valid bits and the entry RAM.
module rsitp_stack import rsitp_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    localparam int SP_W = $clog2(STACK_DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  stk_req_t          req,
    input  logic [ADDR_W-1:0] push_data,
    output logic [ADDR_W-1:0] top
);

    logic [SP_W-1:0]        sp_reg;
    logic [SP_W-1:0]        sp_next;
    logic [SP_W-1:0]        sp_inc;
    logic [SP_W-1:0]        sp_dec;
    logic [STACK_DEPTH-1:0] vld_reg;
    logic [STACK_DEPTH-1:0] vld_next;
    logic                   hit_reg;
    logic [ADDR_W-1:0]      rdata;

    assign sp_inc = (sp_reg == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_reg + 1'b1;
    assign sp_dec = (sp_reg == '0) ? SP_W'(STACK_DEPTH - 1) : sp_reg - 1'b1;

    always_comb
    begin
        sp_next  = sp_reg;
        vld_next = vld_reg;
        if (req.push)
        begin
            sp_next          = sp_inc;
            vld_next[sp_inc] = 1'b1;
        end
        else if (req.pop)
        begin
            sp_next          = sp_dec;
            vld_next[sp_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg  <= '0;
            vld_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            sp_reg  <= sp_next;
            vld_reg <= vld_next;
            hit_reg <= vld_reg[sp_reg];
        end
    end

    rsitp_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (req.push),
        .waddr (sp_inc),
        .wdata (push_data),
        .raddr (sp_reg),
        .rdata (rdata)
    );

    // cleared or never-written entries read as zero
    assign top = hit_reg ? rdata : '0;

    assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH - 1))
        else $error("stack pointer out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(req.push && req.pop))
        else $error("push and pop in the same cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        req.push |=> vld_reg[sp_reg])
        else $error("pushed entry not marked valid");

endmodule

/* src/return_stack_indirect_target_predictor_core.sv */
// Return stack and indirect target predictor top level: request sequencer and tables.
// Path to the result register: plain kinds load it from S_IDLE; indirect predict via S_IND;
// return predict via S_RET_TOP, S_RET_SUM; return update via S_POP, S_LEARN (table reads).
// One request is in flight at a time; plain requests sustain one per cycle while out_stall is low.
// After reset the target and call-size tables are swept over max(INDIRECT_ENTRIES,
// CALL_SIZE_ENTRIES) addresses; in_stall stays high until the cycle after the sweep ends.
module return_stack_indirect_target_predictor_core import rsitp_pkg::*; #(
    parameter int STACK_DEPTH       = DEF_STACK_DEPTH,
    parameter int INDIRECT_ENTRIES  = DEF_INDIRECT_ENTRIES,  // power of two
    parameter int CALL_SIZE_ENTRIES = DEF_CALL_SIZE_ENTRIES  // power of two
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SIZE_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              opcode,
    input  logic [KIND_W-1:0] branch_kind,
    input  logic [ADDR_W-1:0] branch_address,
    input  logic [ADDR_W-1:0] resolved_target,
    input  logic              was_taken,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              prediction_given,
    output logic [ADDR_W-1:0] predicted_target,
    output logic              unconditional
);

    localparam int IND_AW    = $clog2(INDIRECT_ENTRIES);
    localparam int CS_AW     = $clog2(CALL_SIZE_ENTRIES);
    localparam int CLR_DEPTH = (INDIRECT_ENTRIES > CALL_SIZE_ENTRIES) ?
                               INDIRECT_ENTRIES : CALL_SIZE_ENTRIES;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_IND     = 8'b0000_0100,
        S_RET_TOP = 8'b0000_1000,
        S_RET_SUM = 8'b0001_0000,
        S_POP     = 8'b0010_0000,
        S_LEARN   = 8'b0100_0000,
        S_EMIT    = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [HIST_W-1:0] hist_reg;
    logic [HIST_W-1:0] hist_next;
    logic [SIZE_W-1:0] limit_reg;

    logic              item_taken_reg;
    logic [ADDR_W-1:0] item_tgt_reg;
    logic [ADDR_W-1:0] top_reg;
    logic [ADDR_W:0]   diff_reg;

    logic              res_given_reg;
    logic [ADDR_W-1:0] res_target_reg;
    logic              res_taken_reg;

    logic              out_valid_reg;
    logic              out_given_reg;
    logic [ADDR_W-1:0] out_target_reg;
    logic              out_taken_reg;

    logic              in_acc;
    logic              out_free;
    logic              out_load;
    logic              kind_ind;
    logic              kind_push;

    logic              fin_valid;
    logic              fin_given;
    logic [ADDR_W-1:0] fin_target;
    logic              fin_taken;

    stk_req_t          stk_req;
    logic [ADDR_W-1:0] stk_top;

    clr_ctl_t          clr;
    logic [CLR_AW-1:0] clr_addr;

    logic [ADDR_W-1:0] hashed;
    logic [IND_AW-1:0] ind_idx;
    logic              ind_we_item;
    logic [ADDR_W-1:0] ind_rdata;

    logic [ADDR_W-1:0] ret_dist;
    logic              dist_ok;
    logic              learn_we;
    logic [SIZE_W-1:0] cs_rdata;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    assign kind_ind  = (branch_kind == KIND_INDIRECT) || (branch_kind == KIND_IND_CALL);
    assign kind_push = (branch_kind == KIND_CALL) || (branch_kind == KIND_IND_CALL);

    assign hashed  = (branch_address >> 2) ^ ADDR_W'(hist_reg);
    assign ind_idx = hashed[IND_AW-1:0];

    assign ret_dist = diff_reg[ADDR_W] ? (ADDR_W'(0) - diff_reg[ADDR_W-1:0])
                                       : diff_reg[ADDR_W-1:0];
    assign dist_ok  = (ret_dist[ADDR_W-1:SIZE_W] == '0) &&
                      (ret_dist[SIZE_W-1:0] <= limit_reg);

    always_comb
    begin
        state_next  = state_reg;
        hist_next   = hist_reg;
        stk_req     = '0;
        ind_we_item = 1'b0;
        learn_we    = 1'b0;
        fin_valid   = 1'b0;
        fin_given   = 1'b0;
        fin_target  = '0;
        fin_taken   = item_taken_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (!clr.busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    fin_taken = (branch_kind != KIND_COND);
                    if (opcode == OP_PREDICT)
                    begin
                        stk_req.push = kind_push;
                        if (branch_kind == KIND_RETURN)
                        begin
                            state_next = S_RET_TOP;
                        end
                        else if (kind_ind)
                        begin
                            state_next = S_IND;
                        end
                        else
                        begin
                            fin_valid = 1'b1;
                        end
                    end
                    else
                    begin
                        ind_we_item = kind_ind;
                        if (branch_kind == KIND_COND)
                        begin
                            hist_next = {hist_reg[HIST_W-2:0], was_taken};
                        end
                        if (branch_kind == KIND_RETURN)
                        begin
                            stk_req.pop = 1'b1;
                            state_next  = S_POP;
                        end
                        else
                        begin
                            fin_valid = 1'b1;
                        end
                    end
                end
            end
            S_IND:
            begin
                fin_valid  = 1'b1;
                fin_given  = 1'b1;
                fin_target = ind_rdata;
            end
            S_RET_TOP:
            begin
                state_next = S_RET_SUM;
            end
            S_RET_SUM:
            begin
                fin_valid  = 1'b1;
                fin_given  = 1'b1;
                fin_target = top_reg + ADDR_W'(cs_rdata);
            end
            S_POP:
            begin
                state_next = S_LEARN;
            end
            S_LEARN:
            begin
                learn_we  = dist_ok;
                fin_valid = 1'b1;
            end
            S_EMIT:
            begin
                fin_valid  = 1'b1;
                fin_given  = res_given_reg;
                fin_target = res_target_reg;
                fin_taken  = res_taken_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (fin_valid)
        begin
            state_next = out_free ? S_IDLE : S_EMIT;
        end
    end

    assign out_load = fin_valid && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            hist_reg      <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hist_reg  <= hist_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            item_taken_reg <= (branch_kind != KIND_COND);
            item_tgt_reg   <= resolved_target;
        end
        if (state_reg == S_RET_TOP || state_reg == S_POP)
        begin
            top_reg <= stk_top;
        end
        if (state_reg == S_POP)
        begin
            diff_reg <= {1'b0, stk_top} - {1'b0, item_tgt_reg};
        end
        if (fin_valid && !out_free)
        begin
            res_given_reg  <= fin_given;
            res_target_reg <= fin_target;
            res_taken_reg  <= fin_taken;
        end
        if (out_load)
        begin
            out_given_reg  <= fin_given;
            out_target_reg <= fin_target;
            out_taken_reg  <= fin_taken;
        end
    end

    assign out_valid        = out_valid_reg;
    assign prediction_given = out_given_reg;
    assign predicted_target = out_target_reg;
    assign unconditional    = out_taken_reg;

    rsitp_clear #(
        .INDIRECT_ENTRIES  (INDIRECT_ENTRIES),
        .CALL_SIZE_ENTRIES (CALL_SIZE_ENTRIES)
    ) u_clear (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (clr),
        .addr  (clr_addr)
    );

    rsitp_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (stk_req),
        .push_data (branch_address),
        .top       (stk_top)
    );

    rsitp_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (INDIRECT_ENTRIES)
    ) u_ind_ram (
        .clk   (clk),
        .we    (clr.ind_we || ind_we_item),
        .waddr (clr.busy ? clr_addr[IND_AW-1:0] : ind_idx),
        .wdata (clr.busy ? ADDR_W'(0) : resolved_target),
        .raddr (ind_idx),
        .rdata (ind_rdata)
    );

    rsitp_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (CALL_SIZE_ENTRIES)
    ) u_cs_ram (
        .clk   (clk),
        .we    (clr.cs_we || learn_we),
        .waddr (clr.busy ? clr_addr[CS_AW-1:0] : top_reg[CS_AW-1:0]),
        .wdata (clr.busy ? CALL_SIZE_RESET : ret_dist[SIZE_W-1:0]),
        .raddr (stk_top[CS_AW-1:0]),
        .rdata (cs_rdata)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !clr.busy)
        else $error("request accepted during table sweep");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && prediction_given) |-> unconditional)
        else $error("prediction given for a conditional branch");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !prediction_given) |-> (predicted_target == '0))
        else $error("nonzero target without a prediction");

endmodule
